[rtl/mono_gain_box_downscale_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the gain, offset and box downscale block
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MONO_GAIN_BOX_DOWNSCALE_ASSERT_SVH
`define MONO_GAIN_BOX_DOWNSCALE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MGBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MGBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mgbd_pkg.sv]
// ----------------------------------------------------------------------------
// mgbd_pkg
// Shared widths, constants, register codes and stage types of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mgbd_pkg;

  // Field and register widths.
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned BRIGHT_W   = 17;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned MAP_W      = 42;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned ARGB_W     = 32;

  // Fixed point layout: products carry 16 fraction bits, brightness 8.
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned BRIGHT_SHIFT = 8;

  localparam logic [SUM_W-1:0]   SUM_MAX    = 40'h7f_ffff_ffff;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
  localparam logic [ARGB_W-1:0]  ALPHA_WORD = 32'hff00_0000;
  localparam logic [DIM_W-1:0]   ROW_LIMIT  = 13'd4096;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd65536;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST = '0;
  localparam logic [1:0]          SHIFT_RST  = 2'd0;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd4096;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd4096;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN,
    REG_BRIGHTNESS,
    REG_SCALE_SHIFT,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_e;

  // Per-pixel control that travels from the position tracker to the accumulator.
  typedef struct packed {
    logic               first;
    logic               emit;
    logic [1:0]         shift;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
  } pos_info_t;

endpackage

`default_nettype wire

[rtl/mgbd_pix_if.sv]
// ----------------------------------------------------------------------------
// mgbd_pix_if
// Source pixel channel: one monochrome sample and a frame marker per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mgbd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

`default_nettype wire

[rtl/mgbd_out_if.sv]
// ----------------------------------------------------------------------------
// mgbd_out_if
// Result channel: one grey ARGB pixel with its output position per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mgbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb_word;
  logic [11:0] out_column;
  logic [11:0] out_row;

  modport source (output valid, output argb_word, output out_column, output out_row,
                  input ready);
  modport sink   (input valid, input argb_word, input out_column, input out_row,
                  output ready);
endinterface

`default_nettype wire

[rtl/mgbd_pos.sv]
// ----------------------------------------------------------------------------
// mgbd_pos
// Raster position tracker: column and row counters, block corner detection
// and output coordinates with the vertical flip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mgbd_pos #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic                           frame_start_i,
  input  logic [1:0]                     shift_i,
  input  logic [mgbd_pkg::DIM_W-1:0]     image_width_i,
  input  logic [mgbd_pkg::DIM_W-1:0]     image_height_i,
  output logic [$clog2(MAX_WIDTH)-1:0]   idx_o,
  output mgbd_pkg::pos_info_t            info_o
);
  import mgbd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;

  logic [AW-1:0]      col_q, col_d;
  logic [COORD_W-1:0] row_q, row_d;

  logic [WW-1:0]      w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [AW-1:0]      c0, col;
  logic [COORD_W-1:0] r0, row;
  logic [DIM_W-1:0]   r1, nrow;
  logic               wrap_in;
  logic [2:0]         mask;
  logic [WW-1:0]      wout, ox;
  logic [DIM_W-1:0]   hout;
  logic [COORD_W-1:0] oy;
  logic [AW:0]        ncol;

  always_comb begin
    // Clamp the geometry into its usable range.
    if (image_width_i == '0) begin
      w_eff = WW'(1);
    end else if (WW'(image_width_i) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_i);
    end
    if (image_height_i == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height_i > ROW_LIMIT) begin
      h_eff = ROW_LIMIT;
    end else begin
      h_eff = image_height_i;
    end

    // Position of this pixel; counters past a narrowed width wrap here.
    c0      = frame_start_i ? '0 : col_q;
    r0      = frame_start_i ? '0 : row_q;
    wrap_in = (WW'(c0) >= w_eff);
    col     = wrap_in ? '0 : c0;
    r1      = wrap_in ? ({1'b0, r0} + DIM_W'(1)) : {1'b0, r0};
    row     = (r1 >= h_eff) ? '0 : r1[COORD_W-1:0];

    // Block corners and output coordinates.
    mask = 3'((4'd1 << shift_i) - 4'd1);
    wout = w_eff >> shift_i;
    hout = h_eff >> shift_i;
    ox   = WW'(col) >> shift_i;
    oy   = row >> shift_i;

    info_o.first      = ((col[2:0] & mask) == 3'd0) && ((row[2:0] & mask) == 3'd0);
    info_o.emit       = ((col[2:0] & mask) == mask) && ((row[2:0] & mask) == mask) &&
                        (ox < wout) && (DIM_W'(oy) < hout);
    info_o.shift      = shift_i;
    info_o.out_column = ox[COORD_W-1:0];
    info_o.out_row    = COORD_W'(hout - DIM_W'(oy) - DIM_W'(1));
    idx_o             = ox[AW-1:0];

    // Advance to the next raster position.
    ncol = {1'b0, col} + (AW + 1)'(1);
    nrow = {1'b0, row} + DIM_W'(1);
    if (WW'(ncol) >= w_eff) begin
      col_d = '0;
      row_d = (nrow >= h_eff) ? '0 : nrow[COORD_W-1:0];
    end else begin
      col_d = ncol[AW-1:0];
      row_d = row;
    end
  end

  // Counter registers move once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

[rtl/mgbd_accum.sv]
// ----------------------------------------------------------------------------
// mgbd_accum
// Line store of block sums with read-modify-write, gain multiply, offset,
// saturation and conversion of a finished block sum into a grey level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mgbd_accum #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  take_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]          idx_i,
  input  logic [mgbd_pkg::PIX_W-1:0]            pixel_i,
  input  logic [mgbd_pkg::GAIN_W-1:0]           gain_i,
  input  logic signed [mgbd_pkg::BRIGHT_W-1:0]  brightness_i,
  input  mgbd_pkg::pos_info_t                   info_i,
  input  logic                                  move_i,
  output logic                                  valid_o,
  output logic                                  emit_o,
  output logic [mgbd_pkg::LEVEL_W-1:0]          level_o,
  output mgbd_pkg::pos_info_t                   info_o
);
  import mgbd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic                    valid_q;
  logic                    fwd_q;
  logic [AW-1:0]           idx_q;
  pos_info_t               info_q;
  logic [SUM_W-1:0]        prod_q;
  logic signed [SUM_W-1:0] rdata_q;
  logic signed [SUM_W-1:0] fwd_data_q;

  logic signed [SUM_W-1:0] mem [MAX_WIDTH];

  logic [SUM_W-1:0]        prod;
  logic signed [MAP_W-1:0] bright_ext;
  logic signed [MAP_W-1:0] mapped;
  logic signed [SUM_W-1:0] base;
  logic signed [MAP_W:0]   total;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-FRAC_BITS-2:0] quot;

  // Gain product of the incoming sample.
  assign prod = {{(SUM_W-PIX_W){1'b0}}, pixel_i} * {{(SUM_W-GAIN_W){1'b0}}, gain_i};

  // Line store: read at accept, write back when the stage hands its beat on.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      rdata_q <= mem[idx_i];
    end
    if (move_i) begin
      mem[idx_q] <= sum;
    end
  end

  // Stage payload, including the value written back in the same cycle.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      idx_q      <= idx_i;
      info_q     <= info_i;
      prod_q     <= prod;
      fwd_data_q <= sum;
    end
  end

  // Stage control; forward when the previous beat writes the entry just read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      if (take_i) begin
        valid_q <= 1'b1;
        fwd_q   <= move_i && (idx_i == idx_q);
      end else if (move_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Map, accumulate with saturation, and reduce the sum to a level.
  always_comb begin
    bright_ext = {{(MAP_W-BRIGHT_W-BRIGHT_SHIFT){brightness_i[BRIGHT_W-1]}},
                  brightness_i, {BRIGHT_SHIFT{1'b0}}};
    mapped     = $signed({{(MAP_W-SUM_W){1'b0}}, prod_q}) + bright_ext;
    base       = fwd_q ? fwd_data_q : rdata_q;
    if (info_q.first) begin
      total = {mapped[MAP_W-1], mapped};
    end else begin
      total = $signed({{(MAP_W+1-SUM_W){base[SUM_W-1]}}, base}) +
              $signed({mapped[MAP_W-1], mapped});
    end
    if (total > $signed({{(MAP_W+1-SUM_W){1'b0}}, SUM_MAX})) begin
      sum = SUM_MAX;
    end else begin
      sum = total[SUM_W-1:0];
    end

    quot = sum[SUM_W-2:FRAC_BITS] >> {info_q.shift, 1'b0};
    if (sum[SUM_W-1]) begin
      level_o = '0;
    end else if (quot > (SUM_W-FRAC_BITS-1)'(LEVEL_MAX)) begin
      level_o = LEVEL_MAX;
    end else begin
      level_o = quot[LEVEL_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign emit_o  = info_q.emit;
  assign info_o  = info_q;

endmodule

`default_nettype wire

[rtl/mono_gain_box_downscale.sv]
// ----------------------------------------------------------------------------
// mono_gain_box_downscale
// Gain, offset and clamp on a monochrome raster stream with power-of-two box
// downscaling, emitting opaque grey ARGB pixels with flipped row order.
//
//   channel  dir  beat payload                         handshake
//   pix_i    in   pixel_value[16], frame_start[1]      valid / ready
//   res_o    out  argb_word[32], out_column[12],       valid / ready
//                 out_row[12]
//   cfg      in   cfg_idx_i[3], cfg_data_i[24]         cfg_we_i, no wait
//
// One pixel is taken every cycle unless a blocked result holds the accumulate
// stage; a block's last pixel passes that stage and then the output register.
// The accumulator line store has one read and one write port; a write-to-read
// forward covers neighbor pixels of the same block. Reset clears counters,
// registers and pipeline valids; the line store is written by the first row
// of each block and needs no clearing pass. A stalled output only holds the
// input back when the accumulate stage holds a beat that must go out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mono_gain_box_downscale_assert.svh"

module mono_gain_box_downscale #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_SHIFT = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mgbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mgbd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mgbd_pix_if.sink                          pix_i,
  mgbd_out_if.source                        res_o
);
  import mgbd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [GAIN_W-1:0]          gain_q;
  logic signed [BRIGHT_W-1:0] brightness_q;
  logic [1:0]                 scale_shift_q;
  logic [DIM_W-1:0]           image_width_q;
  logic [DIM_W-1:0]           image_height_q;

  logic [1:0]         shift_eff;
  logic               take;
  logic               out_free;
  logic               b_valid, b_emit, b_move;
  logic [AW-1:0]      idx;
  pos_info_t          pos_info, b_info;
  logic [LEVEL_W-1:0] level;

  logic               out_valid_q;
  logic [ARGB_W-1:0]  argb_q;
  logic [COORD_W-1:0] out_column_q;
  logic [COORD_W-1:0] out_row_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q         <= GAIN_RST;
      brightness_q   <= BRIGHT_RST;
      scale_shift_q  <= SHIFT_RST;
      image_width_q  <= WIDTH_RST;
      image_height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN: begin
          gain_q <= cfg_data_i[GAIN_W-1:0];
        end
        REG_BRIGHTNESS: begin
          brightness_q <= cfg_data_i[BRIGHT_W-1:0];
        end
        REG_SCALE_SHIFT: begin
          scale_shift_q <= cfg_data_i[1:0];
        end
        REG_IMAGE_WIDTH: begin
          image_width_q <= cfg_data_i[DIM_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          image_height_q <= cfg_data_i[DIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Shift limited to what the block supports.
  assign shift_eff = ({30'b0, scale_shift_q} > MAX_SHIFT) ? 2'(MAX_SHIFT) : scale_shift_q;

  // Pipeline flow: the accumulate stage drains unless its result is blocked.
  assign out_free    = !out_valid_q || res_o.ready;
  assign b_move      = b_valid && (!b_emit || out_free);
  assign pix_i.ready = !b_valid || b_move;
  assign take        = pix_i.valid && pix_i.ready;

  mgbd_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .frame_start_i  (pix_i.frame_start),
    .shift_i        (shift_eff),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .idx_o          (idx),
    .info_o         (pos_info)
  );

  mgbd_accum #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .idx_i        (idx),
    .pixel_i      (pix_i.pixel_value),
    .gain_i       (gain_q),
    .brightness_i (brightness_q),
    .info_i       (pos_info),
    .move_i       (b_move),
    .valid_o      (b_valid),
    .emit_o       (b_emit),
    .level_o      (level),
    .info_o       (b_info)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b_move && b_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move && b_emit) begin
      argb_q       <= ALPHA_WORD | {8'h00, level, level, level};
      out_column_q <= b_info.out_column;
      out_row_q    <= b_info.out_row;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.argb_word  = argb_q;
  assign res_o.out_column = out_column_q;
  assign res_o.out_row    = out_row_q;

  // A blocked result stays in the accumulate stage.
  `MGBD_ASSERT_NEXT(a_emit_held, b_valid && b_emit && !b_move, b_valid && b_emit, "held result lost")
  // Every accepted beat reaches the accumulate stage.
  `MGBD_ASSERT_NEXT(a_take_lands, take, b_valid, "accepted beat missing")
  // With downscaling, the first pixel of a frame never closes a block.
  `MGBD_ASSERT_NEXT(a_frame_no_emit, take && pix_i.frame_start && shift_eff != 2'd0, !b_emit, "frame start emitted")

endmodule

`default_nettype wire

[test/mgbd_grey_checker.sv]
// ----------------------------------------------------------------------------
// Grey result checker for the gain, offset and box downscale block
// Watches the pixel, result and register ports. It keeps its own model of the
// counters, registers and block accumulators, predicts every grey beat, and
// compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgbd_grey_checker
  import mgbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mgbd_pix_if                   pix_i,
  mgbd_out_if                   res_i,
  output int                    errors_o,
  output int                    waiting_o
);

  localparam int unsigned ACC_DEPTH  = 4096;
  localparam longint      ACC_CAP    = longint'(SUM_MAX);
  localparam int          SHOW_LIMIT = 50;

  typedef struct packed {
    logic [ARGB_W-1:0]  argb;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } grey_pix_t;

  // Register copies, as seen on the write port.
  logic [GAIN_W-1:0]          gain_q;
  logic signed [BRIGHT_W-1:0] bright_q;
  logic [1:0]                 shift_q;
  logic [DIM_W-1:0]           width_q;
  logic [DIM_W-1:0]           height_q;

  // Raster position of the next pixel and the per-column block sums.
  int unsigned col_q;
  int unsigned row_q;
  longint      block_acc [ACC_DEPTH];

  grey_pix_t   grey_q [$];
  int          errors;

  // Map one pixel, add it into its block and queue the grey beat that a
  // completed block gives.
  task automatic accumulate_pixel(input logic [PIX_W-1:0] pv, input logic fs);
    int unsigned w, h, s, m, col, row, idx;
    longint      mapped, acc, q;
    logic [LEVEL_W-1:0] lvl;
    grey_pix_t   want;
    w = (width_q == 0) ? 1 : ((width_q > ACC_DEPTH) ? ACC_DEPTH : width_q);
    h = (height_q == 0) ? 1 : ((height_q > ROW_LIMIT) ? ROW_LIMIT : height_q);
    s = shift_q;
    m = (1 << s) - 1;

    // A frame marker restarts the raster; counters past the width wrap here.
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
    if (row_q >= h) row_q = 0;
    col = col_q;
    row = row_q;

    mapped = longint'(pv) * longint'(gain_q) + longint'(bright_q) * 256;

    // The top-left pixel of a block starts its sum; the rest saturate into it.
    idx = (col >> s) & (ACC_DEPTH - 1);
    if (((row & m) == 0) && ((col & m) == 0)) begin
      acc = mapped;
    end else begin
      acc = block_acc[idx];
      acc = (acc > ACC_CAP - mapped) ? ACC_CAP : acc + mapped;
    end
    if (acc > ACC_CAP) acc = ACC_CAP;
    block_acc[idx] = acc;

    // The bottom-right pixel of a whole block gives the averaged grey level.
    if (((row & m) == m) && ((col & m) == m) &&
        ((col >> s) < (w >> s)) && ((row >> s) < (h >> s))) begin
      if (acc < 0) begin
        lvl = '0;
      end else begin
        q = acc >>> (FRAC_BITS + 2 * s);
        lvl = (q > LEVEL_MAX) ? LEVEL_MAX : q[LEVEL_W-1:0];
      end
      want.argb = ALPHA_WORD | {8'd0, lvl, lvl, lvl};
      want.col  = COORD_W'(col >> s);
      want.row  = COORD_W'((h >> s) - 1 - (row >> s));
      grey_q.push_back(want);
    end

    col_q = col + 1;
    if (col_q >= w) begin
      col_q = 0;
      row_q = row + 1;
      if (row_q >= h) row_q = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grey_pix_t got, want;
    if (!rst_ni) begin
      gain_q   = GAIN_RST;
      bright_q = BRIGHT_RST;
      shift_q  = SHIFT_RST;
      width_q  = WIDTH_RST;
      height_q = HEIGHT_RST;
      col_q    = 0;
      row_q    = 0;
      grey_q.delete();
      errors   = 0;
    end else begin
      if (pix_i.valid && pix_i.ready) accumulate_pixel(pix_i.pixel_value, pix_i.frame_start);

      // Every result beat must match the oldest prediction in all fields.
      if (res_i.valid && res_i.ready) begin
        got.argb = res_i.argb_word;
        got.col  = res_i.out_column;
        got.row  = res_i.out_row;
        if (grey_q.size() == 0) begin
          if (errors < SHOW_LIMIT)
            $display("%0t: unexpected grey beat: expected none, got argb %h col %0d row %0d",
                     $time, got.argb, got.col, got.row);
          errors++;
        end else begin
          want = grey_q.pop_front();
          if (got.argb != want.argb || got.col != want.col || got.row != want.row) begin
            if (errors < SHOW_LIMIT)
              $display("%0t: grey beat differs: expected argb %h col %0d row %0d, got argb %h col %0d row %0d",
                       $time, want.argb, want.col, want.row, got.argb, got.col, got.row);
            errors++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_GAIN:         gain_q   = cfg_data_i[GAIN_W-1:0];
          REG_BRIGHTNESS:   bright_q = cfg_data_i[BRIGHT_W-1:0];
          REG_SCALE_SHIFT:  shift_q  = cfg_data_i[1:0];
          REG_IMAGE_WIDTH:  width_q  = cfg_data_i[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_q = cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
    end
    errors_o  <= errors;
    waiting_o <= grey_q.size();
  end

endmodule

[test/tb_mono_gain_box_downscale.sv]
// ----------------------------------------------------------------------------
// Testbench for the gain, offset and box downscale block
// Drives raster pixel streams under many register settings, from a short
// directed set of extremes to random geometries, shifts, gains and offsets,
// with bursty input and a stalling receiver. A separate checker predicts and
// compares every grey beat; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mono_gain_box_downscale;
  import mgbd_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 880;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  rx_ready = 1'b0;

  mgbd_pix_if pix_ch ();
  mgbd_out_if res_ch ();

  int mismatches;
  int outstanding;
  int cycles      = 0;
  int grey_beats  = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  int stall_mode  = 0;
  int pixels_sent = 0;
  int phases      = 0;

  logic [1:0]       cur_shift;
  logic [DIM_W-1:0] cur_width;

  mono_gain_box_downscale dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_ch),
    .res_o      (res_ch)
  );

  mgbd_grey_checker grey_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_ch),
    .res_i      (res_ch),
    .errors_o   (mismatches),
    .waiting_o  (outstanding)
  );

  always #5 clk_i = ~clk_i;

  assign res_ch.ready = rx_ready;

  // The receiver switches between always ready, mostly ready and mostly stalled.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       rx_ready <= 1'b1;
      1:       rx_ready <= ($urandom_range(0, 3) != 0);
      default: rx_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) grey_beats <= grey_beats + 1;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d grey beats pending", cycles, outstanding);
      $display("mono_gain_box_downscale: mismatch");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Wait until every predicted grey beat has been delivered.
  task automatic wait_drained();
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // One pixel beat, with bursts, random gaps and the odd full drain.
  task automatic send_pixel(input logic [PIX_W-1:0] value, input logic marks_frame);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) begin
        pix_ch.valid <= 1'b0;
        wait_drained();
      end else if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_value <= value;
    pix_ch.frame_start <= marks_frame;
    do @(posedge clk_i); while (!pix_ch.ready);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int count, input bit first_mark, input bit noisy);
    for (int k = 0; k < count; k++)
      send_pixel(rand_pixel(), (k == 0 && first_mark) || (noisy && $urandom_range(0, 63) == 0));
  endtask

  // Stop the stream and let the pipeline empty before registers change.
  task automatic finish_phase();
    pix_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= d;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [GAIN_W-1:0] g, input logic [BRIGHT_W-1:0] b,
                               input logic [1:0] s, input logic [DIM_W-1:0] w,
                               input logic [DIM_W-1:0] h);
    put_reg(REG_GAIN, CFG_DATA_W'(g));
    put_reg(REG_BRIGHTNESS, CFG_DATA_W'(b));
    put_reg(REG_SCALE_SHIFT, CFG_DATA_W'(s));
    put_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    put_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_we_i  <= 1'b0;
    cur_shift = s;
    cur_width = w;
    phases++;
  endtask

  initial begin
    int               base_sent;
    int               rows;
    int               eff_w;
    int               prev_w;
    bit               carry_on;
    logic [GAIN_W-1:0]   g;
    logic [BRIGHT_W-1:0] b;
    logic [1:0]          s;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_GAIN;
    cfg_data_i         = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_value = '0;
    pix_ch.frame_start = 1'b0;
    cur_shift          = SHIFT_RST;
    cur_width          = WIDTH_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: unity gain, no offset, one beat per pixel.
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hffff, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    finish_phase();

    // Full gain: the product alone overflows the accumulator.
    load_settings(24'hffffff, 17'd0, 2'd0, 13'd4, 13'd2);
    send_pixel(16'hffff, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h7fff, 1'b0);
    finish_phase();

    // Zero gain with the most negative offset: every block clamps to black.
    load_settings(24'd0, 17'h10000, 2'd1, 13'd4, 13'd2);
    send_pixels(8, 1'b1, 1'b0);
    finish_phase();

    // Largest offset on a zero-sized geometry, which acts as one by one.
    load_settings(24'd0, 17'h0ffff, 2'd0, 13'd0, 13'd0);
    send_pixels(3, 1'b1, 1'b0);
    finish_phase();

    // Oversize geometry acts as 4096; the flipped row shows the clamped height.
    load_settings(24'h010000, 17'd0, 2'd0, 13'd8191, 13'd8191);
    send_pixels(16, 1'b1, 1'b0);
    finish_phase();

    // Random settings and raster streams; some phases keep the shift, keep or
    // shrink the width and continue the running frame without a marker.
    base_sent = pixels_sent;
    while (pixels_sent - base_sent < RANDOM_PIXELS) begin
      carry_on = ($urandom_range(0, 3) == 0);
      prev_w = (cur_width == 0) ? 1 : ((cur_width > 4096) ? 4096 : cur_width);
      s = carry_on ? cur_shift : 2'($urandom_range(0, 3));
      if (carry_on)
        w = DIM_W'($urandom_range(1, (prev_w < 24) ? prev_w : 24));
      else if ($urandom_range(0, 7) == 0)
        w = '0;
      else
        w = DIM_W'($urandom_range(1, 24));
      case ($urandom_range(0, 7))
        0:       h = 13'd4096;
        1:       h = 13'd8191;
        2:       h = 13'd0;
        3:       h = 13'd4095;
        default: h = DIM_W'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 5))
        0:       g = GAIN_W'($urandom_range(0, 24'hffffff));
        1:       g = 24'hffffff;
        2:       g = '0;
        default: g = GAIN_W'($urandom_range(0, 24'h3ffff));
      endcase
      if ($urandom_range(0, 3) == 0)
        b = BRIGHT_W'($urandom_range(0, 17'h1ffff));
      else
        b = BRIGHT_W'($urandom_range(0, 16383)) - 17'd8192;
      eff_w = (w == 0) ? 1 : w;
      rows  = ($urandom_range(1, 2) << s) + $urandom_range(0, 1);
      load_settings(g, b, s, w, h);
      send_pixels(eff_w * rows, !carry_on, 1'b1);
      finish_phase();
    end

    $display("Checked %0d grey beats from %0d pixel beats over %0d register settings.",
             grey_beats, pixels_sent, phases + 1);
    $display("Covered all shifts, zero to oversize geometry, saturation, black clamping, partial blocks and frame restarts.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("mono_gain_box_downscale: match");
    end else begin
      $display("mono_gain_box_downscale: mismatch");
    end
    $finish;
  end

endmodule

[mono_gain_box_downscale.f]
+incdir+rtl
rtl/mgbd_pkg.sv
rtl/mgbd_pix_if.sv
rtl/mgbd_out_if.sv
rtl/mgbd_pos.sv
rtl/mgbd_accum.sv
rtl/mono_gain_box_downscale.sv
test/mgbd_grey_checker.sv
test/tb_mono_gain_box_downscale.sv
